// File: hw/rtl/stscp_pkg.sv
// Shared types, character codes and decode functions for the serial time-set parser.
// Depends on nothing; the front end, back end and top level refer to it by scoped names.
package stscp_pkg;

  localparam int unsigned StoreDepth = 15;
  localparam int unsigned FieldChars = StoreDepth - 1;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharVt    = 8'h0B;
  localparam logic [7:0] CharFf    = 8'h0C;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharT     = 8'h54;

  localparam logic [7:0] YearOffset = 8'(2000);

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t                           echo;
    logic                            set;
    logic [FieldChars-1:0][7:0]      chars;
  } cmd_t;

  typedef struct packed {
    byte_t echo;
    logic  set;
    byte_t year;
    byte_t month;
    byte_t day;
    byte_t hour;
    byte_t minute;
    byte_t second;
  } val_t;

  typedef val_t res_t;

  // Decimal text conversion over up to four characters, kept to the low 8 bits.
  function automatic byte_t parse_field(input logic [3:0][7:0] chars, input logic [2:0] len);
    byte_t      v;
    logic       neg;
    logic [1:0] phase;
    byte_t      c;
    logic       is_digit;
    logic       is_space;
    v     = '0;
    neg   = 1'b0;
    phase = 2'd0;
    for (int i = 0; i < 4; i++) begin
      c        = chars[i];
      is_digit = (c >= CharZero) && (c <= CharNine);
      is_space = (c == CharSpace) || (c == CharTab) || (c == CharVt) || (c == CharFf) ||
                 (c == CharCr) || (c == CharLf);
      if (3'(i) < len) begin
        if (phase == 2'd0) begin
          if (is_space) begin
            phase = 2'd0;
          end else if (c == CharPlus || c == CharMinus) begin
            neg   = (c == CharMinus);
            phase = 2'd1;
          end else if (is_digit) begin
            v     = c - CharZero;
            phase = 2'd1;
          end else begin
            phase = 2'd2;
          end
        end else if (phase == 2'd1) begin
          if (is_digit) begin
            v = 8'(v * 8'd10) + (c - CharZero);
          end else begin
            phase = 2'd2;
          end
        end
      end
    end
    return neg ? 8'(-v) : v;
  endfunction

  // Packed BCD of an 8-bit value; the tens digit keeps only its low four bits.
  function automatic byte_t pack_bcd(input byte_t b);
    logic [18:0] p;
    logic [4:0]  q;
    byte_t       r;
    p = 19'(b) * 19'd205;
    q = p[15:11];
    r = b - (8'(q) * 8'd10);
    return {q[3:0], r[3:0]};
  endfunction

endpackage

// File: hw/rtl/stscp_fifo.sv
// Small first-in first-out queue of register entries with push/full and pop/empty sides.
// Depends on nothing; used twice by the serial time-set parser.
module stscp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW:0]   wptr_q, wptr_d;
  logic [AddrW:0]   rptr_q, rptr_d;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (wptr_q == rptr_q);
  assign full_o  = (wptr_q[AddrW-1:0] == rptr_q[AddrW-1:0]) && (wptr_q[AddrW] != rptr_q[AddrW]);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
  assign rptr_d  = do_pop ? rptr_q + 1'b1 : rptr_q;
  assign rdata_o = mem_q[rptr_q[AddrW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q[AddrW-1:0]] <= wdata_i;
    end
  end

endmodule

// File: hw/rtl/stscp_front.sv
// Front end: keeps the line count and the first characters of the line and classifies each byte.
// Depends on stscp_pkg for the character codes and the command type.
module stscp_front #(
  parameter int unsigned LineCapacity = 31
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        rx_byte_i,
  output stscp_pkg::cmd_t   cmd_o
);

  localparam int unsigned CountW = $clog2(LineCapacity + 1);

  logic [CountW-1:0] count_q, count_d;
  logic [7:0]        store_q [stscp_pkg::StoreDepth];
  logic              is_eol;
  logic              room;
  logic              in_store;

  assign is_eol   = (rx_byte_i == stscp_pkg::CharCr) || (rx_byte_i == stscp_pkg::CharLf);
  assign room     = (count_q < CountW'(LineCapacity));
  assign in_store = (count_q < CountW'(stscp_pkg::StoreDepth));

  always_comb begin
    count_d = count_q;
    if (accept_i) begin
      if (is_eol) begin
        count_d = '0;
      end else if (room) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && !is_eol && in_store) begin
      store_q[count_q[3:0]] <= rx_byte_i;
    end
  end

  always_comb begin
    cmd_o.echo = rx_byte_i;
    cmd_o.set  = is_eol && (count_q == CountW'(stscp_pkg::StoreDepth)) &&
                 (store_q[0] == stscp_pkg::CharT);
    for (int k = 0; k < stscp_pkg::FieldChars; k++) begin
      cmd_o.chars[k] = store_q[k+1];
    end
  end

endmodule

// File: hw/rtl/stscp_back.sv
// Back end: parses the six fields of a command, converts them to packed BCD and queues results.
// Depends on stscp_pkg for the types and functions and on stscp_fifo for the result queue.
module stscp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_empty_i,
  output logic              cmd_pop_o,
  input  stscp_pkg::cmd_t   cmd_i,
  input  logic              pop_i,
  output logic              empty_o,
  output stscp_pkg::res_t   res_o
);

  logic               val_valid_q;
  stscp_pkg::val_t    val_q, val_d;
  stscp_pkg::res_t    res_d;
  logic               res_full;
  logic               advance;

  assign advance   = !val_valid_q || !res_full;
  assign cmd_pop_o = !cmd_empty_i && advance;

  always_comb begin
    val_d.echo   = cmd_i.echo;
    val_d.set    = cmd_i.set;
    val_d.year   = stscp_pkg::parse_field({cmd_i.chars[3], cmd_i.chars[2],
                                           cmd_i.chars[1], cmd_i.chars[0]}, 3'd4)
                   - stscp_pkg::YearOffset;
    val_d.month  = stscp_pkg::parse_field({16'h0, cmd_i.chars[5], cmd_i.chars[4]}, 3'd2);
    val_d.day    = stscp_pkg::parse_field({16'h0, cmd_i.chars[7], cmd_i.chars[6]}, 3'd2);
    val_d.hour   = stscp_pkg::parse_field({16'h0, cmd_i.chars[9], cmd_i.chars[8]}, 3'd2);
    val_d.minute = stscp_pkg::parse_field({16'h0, cmd_i.chars[11], cmd_i.chars[10]}, 3'd2);
    val_d.second = stscp_pkg::parse_field({16'h0, cmd_i.chars[13], cmd_i.chars[12]}, 3'd2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_valid_q <= 1'b0;
    end else if (advance) begin
      val_valid_q <= cmd_pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      val_q <= val_d;
    end
  end

  always_comb begin
    res_d.echo   = val_q.echo;
    res_d.set    = val_q.set;
    res_d.year   = val_q.set ? stscp_pkg::pack_bcd(val_q.year) : '0;
    res_d.month  = val_q.set ? stscp_pkg::pack_bcd(val_q.month) : '0;
    res_d.day    = val_q.set ? stscp_pkg::pack_bcd(val_q.day) : '0;
    res_d.hour   = val_q.set ? stscp_pkg::pack_bcd(val_q.hour) : '0;
    res_d.minute = val_q.set ? stscp_pkg::pack_bcd(val_q.minute) : '0;
    res_d.second = val_q.set ? stscp_pkg::pack_bcd(val_q.second) : '0;
  end

  stscp_fifo #(
    .Width($bits(stscp_pkg::res_t)),
    .Depth(2)
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (val_valid_q),
    .full_o (res_full),
    .wdata_i(res_d),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .rdata_o(res_o)
  );

endmodule

// File: hw/rtl/serial_time_set_command_parser.sv
// Top level of the serial time-set command parser: front end, command queue and back end.
// Depends on stscp_pkg, stscp_fifo, stscp_front and stscp_back.
//
//   channel   handshake          payload
//   input     push / full        rx_byte_i
//   result    empty / pop        echo_byte_o, time_set_o, year..second_bcd_o
//
// One byte is taken per cycle while full is low, and every byte gives one result transaction.
// An accepted byte moves from the command queue into the parse register and then into the
// result queue, where it becomes visible; a full result queue holds it in the parse register.
// Reset clears the line count and both queues; the stored characters need no reset.
// A held-off pop fills the result queue and then the command queue, which raises full.
module serial_time_set_command_parser #(
  parameter int unsigned LINE_CAPACITY = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] echo_byte_o,
  output logic       time_set_o,
  output logic [7:0] year_bcd_o,
  output logic [7:0] month_bcd_o,
  output logic [7:0] day_bcd_o,
  output logic [7:0] hour_bcd_o,
  output logic [7:0] minute_bcd_o,
  output logic [7:0] second_bcd_o
);

  logic             accept;
  stscp_pkg::cmd_t  cmd_in;
  stscp_pkg::cmd_t  cmd_out;
  logic             cmd_empty;
  logic             cmd_pop;
  stscp_pkg::res_t  res;

  assign accept = push && !full;

  stscp_front #(
    .LineCapacity(LINE_CAPACITY)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .rx_byte_i(rx_byte_i),
    .cmd_o    (cmd_in)
  );

  stscp_fifo #(
    .Width($bits(stscp_pkg::cmd_t)),
    .Depth(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (accept),
    .full_o (full),
    .wdata_i(cmd_in),
    .pop_i  (cmd_pop),
    .empty_o(cmd_empty),
    .rdata_o(cmd_out)
  );

  stscp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .cmd_i      (cmd_out),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (res)
  );

  assign echo_byte_o  = res.echo;
  assign time_set_o   = res.set;
  assign year_bcd_o   = res.year;
  assign month_bcd_o  = res.month;
  assign day_bcd_o    = res.day;
  assign hour_bcd_o   = res.hour;
  assign minute_bcd_o = res.minute;
  assign second_bcd_o = res.second;

  a_cmd_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !cmd_empty)
    else $error("An accepted transaction did not reach the command queue.");

  a_cmd_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("The back end popped an empty command queue.");

  a_clear_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !time_set_o) |-> (year_bcd_o == 8'h00 && month_bcd_o == 8'h00 &&
      day_bcd_o == 8'h00 && hour_bcd_o == 8'h00 && minute_bcd_o == 8'h00 &&
      second_bcd_o == 8'h00))
    else $error("Time fields are nonzero without a set strobe.");

  a_units_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (year_bcd_o[3:0] <= 4'd9 && month_bcd_o[3:0] <= 4'd9 &&
      day_bcd_o[3:0] <= 4'd9 && hour_bcd_o[3:0] <= 4'd9 &&
      minute_bcd_o[3:0] <= 4'd9 && second_bcd_o[3:0] <= 4'd9))
    else $error("A units digit of a time field is above nine.");

endmodule
